### hdl/sou_pkg.sv
// Shared types, constants and codes of the set operation unit.
package sou_pkg;

   localparam int SET_W      = 64;
   localparam int SET_BITS   = 64;
   localparam int LIMIT_BITS = (SET_BITS < SET_W) ? SET_BITS : SET_W;
   localparam int IDX_W      = $clog2(SET_W);
   localparam int COUNT_W    = 7;
   localparam int MEMBER_W   = 16;
   localparam int DIFF_W     = MEMBER_W + 1;
   localparam int MODE_W     = 4;
   localparam int ERR_W      = 2;

   typedef enum logic [MODE_W-1:0] {
      OP_AND    = 4'd0,
      OP_OR     = 4'd1,
      OP_DIFF   = 4'd2,
      OP_XOR    = 4'd3,
      OP_EQ     = 4'd4,
      OP_NE     = 4'd5,
      OP_SUBSET = 4'd6,
      OP_MEMBER = 4'd7,
      OP_INCL   = 4'd8,
      OP_EXCL   = 4'd9,
      OP_CARD   = 4'd10,
      OP_SINGLE = 4'd11,
      OP_RANGE  = 4'd12
   } mode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE   = 2'd0,
      ERR_RANGE  = 2'd1,
      ERR_OPCODE = 2'd2
   } err_type;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [SET_W-1:0]           set_a;
      logic [SET_W-1:0]           set_b;
      logic signed [MEMBER_W-1:0] member_first;
      logic signed [MEMBER_W-1:0] member_last;
      logic signed [MEMBER_W-1:0] member_offset;
   } req_type;

   typedef struct packed {
      logic [SET_W-1:0]   set_result;
      logic               flag_result;
      logic [COUNT_W-1:0] count;
      logic [ERR_W-1:0]   error_code;
   } rsp_type;

endpackage

### hdl/set_operation_unit_top.sv
// Throughput: one beat per cycle while the response side takes beats; an input
// register, the set logic with its 64-bit population count, and a response
// register form the path from an accepted request beat to its response beat.
// Reset (synchronous, active high) empties both stages; payload is not reset.
// Stalls on the response side back up through both registers without loss.
module set_operation_unit_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [sou_pkg::MODE_W-1:0]             req_mode,
   input  logic [sou_pkg::SET_W-1:0]              req_set_a,
   input  logic [sou_pkg::SET_W-1:0]              req_set_b,
   input  logic signed [sou_pkg::MEMBER_W-1:0]    req_member_first,
   input  logic signed [sou_pkg::MEMBER_W-1:0]    req_member_last,
   input  logic signed [sou_pkg::MEMBER_W-1:0]    req_member_offset,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sou_pkg::SET_W-1:0]              rsp_set_result,
   output logic                                   rsp_flag_result,
   output logic [sou_pkg::COUNT_W-1:0]            rsp_count,
   output logic [sou_pkg::ERR_W-1:0]              rsp_error_code
);
   import sou_pkg::*;

   req_type stage_ff;
   req_type stage_in;
   logic    stage_valid_ff;
   logic    stage_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    rsp_load;
   logic    stage_load;

   sou_alu u_alu (
      .req (stage_ff),
      .rsp (rsp_in)
   );

   always_comb begin
      rsp_load       = !rsp_valid_ff || rsp_ready;
      stage_load     = !stage_valid_ff || rsp_load;
      req_ready      = stage_load;
      stage_in       = '{mode: req_mode, set_a: req_set_a, set_b: req_set_b,
                         member_first: req_member_first, member_last: req_member_last,
                         member_offset: req_member_offset};
      stage_valid_in = stage_load ? req_valid : stage_valid_ff;
      rsp_valid_in   = rsp_load ? stage_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // hold payload while its stage is stalled
   always_ff @(posedge clock) begin
      if (stage_load) stage_ff <= stage_in;
      if (rsp_load)   rsp_ff   <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_set_result  = rsp_ff.set_result;
   assign rsp_flag_result = rsp_ff.flag_result;
   assign rsp_count       = rsp_ff.count;
   assign rsp_error_code  = rsp_ff.error_code;

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> stage_valid_ff)
      else $error("accepted request beat did not reach the input stage");

   a_stage_moves_on: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && rsp_load |=> rsp_valid_ff)
      else $error("input stage beat lost on its way to the response register");

   a_bad_opcode_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code == ERR_OPCODE) |->
         (rsp_set_result == '0) && !rsp_flag_result && (rsp_count == '0))
      else $error("bad opcode response carries nonzero fields");

   a_count_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_count != '0) |->
         (rsp_set_result == '0) && !rsp_flag_result && (rsp_error_code == ERR_NONE))
      else $error("cardinality response mixed with other results");

endmodule

### hdl/sou_popcount.sv
// Population count of one set word as a three-level adder tree.
module sou_popcount (
   input  logic [sou_pkg::SET_W-1:0]   set_bits,
   output logic [sou_pkg::COUNT_W-1:0] count
);
   import sou_pkg::*;

   localparam int NIB_N = SET_W / 4;
   localparam int GRP_N = NIB_N / 4;

   logic [2:0] nib [NIB_N];
   logic [4:0] grp [GRP_N];

   always_comb begin
      for (int i = 0; i < NIB_N; i++) begin
         nib[i] = 3'(set_bits[4*i]) + 3'(set_bits[4*i+1])
                + 3'(set_bits[4*i+2]) + 3'(set_bits[4*i+3]);
      end
      for (int g = 0; g < GRP_N; g++) begin
         grp[g] = 5'(nib[4*g]) + 5'(nib[4*g+1]) + 5'(nib[4*g+2]) + 5'(nib[4*g+3]);
      end
      count = COUNT_W'(grp[0]) + COUNT_W'(grp[1]) + COUNT_W'(grp[2]) + COUNT_W'(grp[3]);
   end

endmodule

### hdl/sou_alu.sv
// Combinational set operations, flags, cardinality and range checks.
module sou_alu (
   input  sou_pkg::req_type req,
   output sou_pkg::rsp_type rsp
);
   import sou_pkg::*;

   localparam logic signed [DIFF_W-1:0] LIMIT_S = DIFF_W'(LIMIT_BITS);
   localparam logic [SET_W-1:0]         ONES    = {SET_W{1'b1}};
   localparam logic [IDX_W-1:0]         TOP_IDX = IDX_W'(SET_W - 1);

   logic signed [DIFF_W-1:0] first_x;
   logic signed [DIFF_W-1:0] last_x;
   logic signed [DIFF_W-1:0] diff;
   logic                     first_ok;
   logic                     last_ok;
   logic                     diff_ok;
   logic [IDX_W-1:0]         idx_first;
   logic [IDX_W-1:0]         idx_last;
   logic [IDX_W-1:0]         idx_diff;
   logic [SET_W-1:0]         bit_first;
   logic [SET_W-1:0]         span;
   logic [COUNT_W-1:0]       pop;

   sou_popcount u_popcount (
      .set_bits (req.set_a),
      .count    (pop)
   );

   always_comb begin
      first_x   = {req.member_first[MEMBER_W-1], req.member_first};
      last_x    = {req.member_last[MEMBER_W-1], req.member_last};
      diff      = first_x - {req.member_offset[MEMBER_W-1], req.member_offset};
      first_ok  = (first_x >= 0) && (first_x < LIMIT_S);
      last_ok   = (last_x >= 0) && (last_x < LIMIT_S);
      diff_ok   = (diff >= 0) && (diff < LIMIT_S);
      idx_first = req.member_first[IDX_W-1:0];
      idx_last  = req.member_last[IDX_W-1:0];
      idx_diff  = diff[IDX_W-1:0];
      bit_first = ONES & (SET_W'(1) << idx_first);
      span      = (ONES << idx_first) & (ONES >> (TOP_IDX - idx_last));

      rsp = '0;
      case (mode_type'(req.mode))
         OP_AND:    rsp.set_result = req.set_a & req.set_b;
         OP_OR:     rsp.set_result = req.set_a | req.set_b;
         OP_DIFF:   rsp.set_result = req.set_a & ~req.set_b;
         OP_XOR:    rsp.set_result = req.set_a ^ req.set_b;
         OP_EQ:     rsp.flag_result = (req.set_a == req.set_b);
         OP_NE:     rsp.flag_result = (req.set_a != req.set_b);
         OP_SUBSET: rsp.flag_result = ((req.set_a & req.set_b) == req.set_a);
         OP_MEMBER: begin
            if (diff_ok) rsp.flag_result = req.set_a[idx_diff];
            else         rsp.error_code  = ERR_RANGE;
         end
         OP_INCL: begin
            rsp.set_result = first_ok ? (req.set_a | bit_first) : req.set_a;
            if (!first_ok) rsp.error_code = ERR_RANGE;
         end
         OP_EXCL: begin
            rsp.set_result = first_ok ? (req.set_a & ~bit_first) : req.set_a;
            if (!first_ok) rsp.error_code = ERR_RANGE;
         end
         OP_CARD:   rsp.count = pop;
         OP_SINGLE: begin
            if (first_ok) rsp.set_result = bit_first;
            else          rsp.error_code = ERR_RANGE;
         end
         OP_RANGE: begin
            // reversed bounds count as out of range
            if (first_ok && last_ok && (first_x <= last_x)) rsp.set_result = span;
            else                                            rsp.error_code = ERR_RANGE;
         end
         default:   rsp.error_code = ERR_OPCODE;
      endcase
   end

endmodule

### test/tb.sv
// Self-checking testbench of the set operation unit: directed table, then paced random traffic.
`timescale 1ns / 100ps

module tb;
   import sou_pkg::*;

   localparam int                STALL_LIMIT  = 2000;
   localparam int                PHASE_BEATS  = 256;
   localparam int                BACKLOG_HOLD = 64;
   localparam int                BACKLOG_SPAN = 200;
   localparam logic [MODE_W-1:0] MODE_MAX     = '1;

   typedef enum int {
      PH_STEADY,
      PH_SEND_GAPS,
      PH_RECV_STALLS,
      PH_BOTH,
      PH_BACKLOG
   } phase_type;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } table_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [MODE_W-1:0]          req_mode = '0;
   logic [SET_W-1:0]           req_set_a = '0;
   logic [SET_W-1:0]           req_set_b = '0;
   logic signed [MEMBER_W-1:0] req_member_first = '0;
   logic signed [MEMBER_W-1:0] req_member_last = '0;
   logic signed [MEMBER_W-1:0] req_member_offset = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [SET_W-1:0]           rsp_set_result;
   logic                       rsp_flag_result;
   logic [COUNT_W-1:0]         rsp_count;
   logic [ERR_W-1:0]           rsp_error_code;

   phase_type     phase = PH_STEADY;
   rsp_type       pending_results[$];
   table_row_type directed_rows[$];
   int            beats_sent = 0;
   int            beats_checked = 0;
   int            mismatches = 0;
   int            backlog_cycles = 0;
   int            quiet_cycles = 0;

   set_operation_unit_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_set_a         (req_set_a),
      .req_set_b         (req_set_b),
      .req_member_first  (req_member_first),
      .req_member_last   (req_member_last),
      .req_member_offset (req_member_offset),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_set_result    (rsp_set_result),
      .rsp_flag_result   (rsp_flag_result),
      .rsp_count         (rsp_count),
      .rsp_error_code    (rsp_error_code)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic bit member_in_set(int m);
      return m >= 0 && m < LIMIT_BITS;
   endfunction

   // Expected response of one request beat.
   function automatic rsp_type compute_set_op(req_type r);
      rsp_type o;
      int      first;
      int      last;
      int      delta;
      int      members;
      o       = '0;
      first   = $signed(r.member_first);
      last    = $signed(r.member_last);
      delta   = first - $signed(r.member_offset);
      members = 0;
      case (r.mode)
         OP_AND:    o.set_result = r.set_a & r.set_b;
         OP_OR:     o.set_result = r.set_a | r.set_b;
         OP_DIFF:   o.set_result = r.set_a & ~r.set_b;
         OP_XOR:    o.set_result = r.set_a ^ r.set_b;
         OP_EQ:     o.flag_result = (r.set_a == r.set_b);
         OP_NE:     o.flag_result = (r.set_a != r.set_b);
         OP_SUBSET: o.flag_result = ((r.set_a & ~r.set_b) == '0);
         OP_MEMBER: begin
            if (member_in_set(delta)) o.flag_result = r.set_a[delta];
            else o.error_code = ERR_RANGE;
         end
         OP_INCL, OP_EXCL: begin
            o.set_result = r.set_a;
            if (!member_in_set(first)) o.error_code = ERR_RANGE;
            else o.set_result[first] = (r.mode == OP_INCL);
         end
         OP_CARD: begin
            for (int i = 0; i < SET_W; i++) members += r.set_a[i];
            o.count = COUNT_W'(members);
         end
         OP_SINGLE: begin
            if (member_in_set(first)) o.set_result[first] = 1'b1;
            else o.error_code = ERR_RANGE;
         end
         OP_RANGE: begin
            if (member_in_set(first) && member_in_set(last) && first <= last) begin
               for (int i = first; i <= last; i++) o.set_result[i] = 1'b1;
            end else begin
               o.error_code = ERR_RANGE;
            end
         end
         default: o.error_code = ERR_OPCODE;
      endcase
      return o;
   endfunction

   function automatic logic [SET_W-1:0] random_set();
      logic [SET_W-1:0] s;
      s = SET_W'({$urandom, $urandom});
      case ($urandom_range(5))
         0: s = '0;
         1: s = '1;
         2: s = SET_W'(1) << $urandom_range(SET_W - 1);
         3: s = s & SET_W'({$urandom, $urandom});
         4: s = s | SET_W'({$urandom, $urandom});
         default: ;
      endcase
      return s;
   endfunction

   function automatic logic signed [MEMBER_W-1:0] random_member();
      logic signed [MEMBER_W-1:0] m;
      case ($urandom_range(5))
         4: begin
            case ($urandom_range(3))
               0: m = -16'sd1;
               1: m = '0;
               2: m = MEMBER_W'(LIMIT_BITS - 1);
               default: m = MEMBER_W'(LIMIT_BITS);
            endcase
         end
         5: m = MEMBER_W'($urandom);
         default: m = MEMBER_W'($urandom_range(LIMIT_BITS - 1));
      endcase
      return m;
   endfunction

   function automatic req_type random_request();
      req_type r;
      if ($urandom_range(19) == 0)
         r.mode = MODE_W'($urandom_range(int'(MODE_MAX), int'(OP_RANGE) + 1));
      else
         r.mode = MODE_W'($urandom_range(int'(OP_RANGE)));
      r.set_a = random_set();
      r.set_b = random_set();
      case ($urandom_range(3))
         0: r.set_b = r.set_a;
         1: r.set_b = r.set_a | random_set();
         default: ;
      endcase
      r.member_first = random_member();
      r.member_last  = random_member();
      if ($urandom_range(3) == 0) r.member_offset = MEMBER_W'($urandom);
      else r.member_offset = MEMBER_W'($urandom_range(400)) - 16'sd200;
      // aim the member test at the set most of the time
      if (r.mode == OP_MEMBER && $urandom_range(3) != 0)
         r.member_first = r.member_offset + random_member();
      if (r.mode == OP_RANGE && $urandom_range(1) == 0)
         r.member_last = r.member_first + MEMBER_W'($urandom_range(24)) - 16'sd2;
      return r;
   endfunction

   task automatic add_row(input logic [MODE_W-1:0] mode, input logic [SET_W-1:0] a,
                          input logic [SET_W-1:0] b, input logic signed [MEMBER_W-1:0] first,
                          input logic signed [MEMBER_W-1:0] last,
                          input logic signed [MEMBER_W-1:0] offset, input bit typed,
                          input logic [SET_W-1:0] set_want, input logic flag_want,
                          input logic [COUNT_W-1:0] count_want,
                          input logic [ERR_W-1:0] err_want);
      table_row_type t;
      t.req.mode             = mode;
      t.req.set_a            = a;
      t.req.set_b            = b;
      t.req.member_first     = first;
      t.req.member_last      = last;
      t.req.member_offset    = offset;
      t.typed                = typed;
      t.want.set_result      = set_want;
      t.want.flag_result     = flag_want;
      t.want.count           = count_want;
      t.want.error_code      = err_want;
      directed_rows.push_back(t);
   endtask

   // Offer one request beat and hold it until accepted.
   task automatic offer_beat(input req_type item, input bit typed, input rsp_type want);
      int gap_pct;
      gap_pct = (phase == PH_SEND_GAPS) ? 47 : (phase == PH_BOTH) ? 17 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= item.mode;
      req_set_a         <= item.set_a;
      req_set_b         <= item.set_b;
      req_member_first  <= item.member_first;
      req_member_last   <= item.member_last;
      req_member_offset <= item.member_offset;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(typed ? want : compute_set_op(item));
      beats_sent++;
   endtask

   // Response side: check each beat, then pick next cycle's ready.
   always @(posedge clock) begin
      rsp_type got;
      int      stall_pct;
      got.set_result  = rsp_set_result;
      got.flag_result = rsp_flag_result;
      got.count       = rsp_count;
      got.error_code  = rsp_error_code;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: response beat with nothing pending: set=%h flag=%b count=%0d err=%0d",
                     $time, got.set_result, got.flag_result, got.count, got.error_code);
         end else begin
            if (got !== pending_results[0]) begin
               mismatches++;
               $display("%0t: mismatch expected set=%h flag=%b count=%0d err=%0d",
                        $time, pending_results[0].set_result, pending_results[0].flag_result,
                        pending_results[0].count, pending_results[0].error_code);
               $display("%0t:          actual   set=%h flag=%b count=%0d err=%0d",
                        $time, got.set_result, got.flag_result, got.count, got.error_code);
            end
            void'(pending_results.pop_front());
            beats_checked++;
         end
      end
      stall_pct = (phase == PH_RECV_STALLS) ? 47 : (phase == PH_BOTH) ? 17 : 0;
      backlog_cycles <= (phase == PH_BACKLOG) ? backlog_cycles + 1 : 0;
      if (reset)
         rsp_ready <= 1'b0;
      else if (phase == PH_BACKLOG)
         rsp_ready <= (backlog_cycles % BACKLOG_SPAN) >= BACKLOG_HOLD;
      else
         rsp_ready <= $urandom_range(99) >= stall_pct;
   end

   // Watchdog: give up when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
         $display("set_operation_unit_top regression: fail");
         $finish;
      end
   end

   initial begin
      add_row(OP_AND, '1, '0, '0, '0, '0, 1, '0, 0, '0, ERR_NONE);
      add_row(OP_OR, '0, '1, '1, '1, '1, 1, '1, 0, '0, ERR_NONE);
      add_row(OP_DIFF, '1, '1, '0, '0, '0, 1, '0, 0, '0, ERR_NONE);
      add_row(OP_XOR, {32{2'b01}}, {32{2'b10}}, '0, '0, '0, 1, '1, 0, '0, ERR_NONE);
      add_row(OP_EQ, '1, '1, '0, '0, '0, 1, '0, 1, '0, ERR_NONE);
      add_row(OP_NE, '1, '1, '0, '0, '0, 1, '0, 0, '0, ERR_NONE);
      add_row(OP_SUBSET, '0, random_set(), '0, '0, '0, 1, '0, 1, '0, ERR_NONE);
      add_row(OP_SUBSET, random_set(), random_set(), '0, '0, '0, 0, '0, 0, '0, ERR_NONE);
      add_row(OP_MEMBER, '1, '0, 16'sd63, '0, '0, 1, '0, 1, '0, ERR_NONE);
      add_row(OP_MEMBER, '1, '0, 16'sd64, '0, '0, 1, '0, 0, '0, ERR_RANGE);
      // differences past the 16-bit range must not wrap
      add_row(OP_MEMBER, '1, '1, 16'sh8000, '0, 16'sh7fff, 1, '0, 0, '0, ERR_RANGE);
      add_row(OP_MEMBER, '1, '1, 16'sh7fff, '0, 16'sh8000, 1, '0, 0, '0, ERR_RANGE);
      add_row(OP_MEMBER, random_set(), '0, 16'sd100, '0, 16'sd37, 0, '0, 0, '0, ERR_NONE);
      add_row(OP_INCL, '0, '0, 16'sd63, '0, '0, 1, {1'b1, 63'b0}, 0, '0, ERR_NONE);
      add_row(OP_INCL, random_set(), '0, 16'sd64, '0, '0, 0, '0, 0, '0, ERR_NONE);
      add_row(OP_EXCL, '1, '0, '0, '0, '0, 1, {{63{1'b1}}, 1'b0}, 0, '0, ERR_NONE);
      add_row(OP_EXCL, random_set(), '0, -16'sd1, '0, '0, 0, '0, 0, '0, ERR_NONE);
      add_row(OP_CARD, '1, '0, '0, '0, '0, 1, '0, 0, COUNT_W'(64), ERR_NONE);
      add_row(OP_CARD, '0, '1, '0, '0, '0, 1, '0, 0, '0, ERR_NONE);
      add_row(OP_SINGLE, '1, '1, '0, '0, '0, 1, SET_W'(1), 0, '0, ERR_NONE);
      add_row(OP_SINGLE, '1, '1, 16'sh7fff, '0, '0, 1, '0, 0, '0, ERR_RANGE);
      add_row(OP_RANGE, '0, '0, '0, 16'sd63, '0, 1, '1, 0, '0, ERR_NONE);
      add_row(OP_RANGE, '1, '1, 16'sd5, 16'sd4, '0, 1, '0, 0, '0, ERR_RANGE);
      add_row(OP_RANGE, '0, '0, 16'sd7, 16'sd7, '0, 1, SET_W'(1) << 7, 0, '0, ERR_NONE);
      add_row(OP_RANGE, '1, '1, 16'sd10, 16'sd64, '0, 1, '0, 0, '0, ERR_RANGE);
      add_row(MODE_W'(int'(OP_RANGE) + 1), '1, '1, '1, '1, '1, 1, '0, 0, '0, ERR_OPCODE);
      add_row(MODE_MAX, '1, '1, '1, '1, '1, 1, '0, 0, '0, ERR_OPCODE);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_beat(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      for (int p = int'(PH_STEADY); p <= int'(PH_BACKLOG); p++) begin
         phase <= phase_type'(p);
         repeat (PHASE_BEATS) offer_beat(random_request(), 0, '0);
      end
      req_valid <= 1'b0;
      phase     <= PH_STEADY;

      // drain, then keep watching for stray beats
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d request beats: directed table, then random traffic under",
               beats_sent);
      $display("steady, sender-gap, receiver-stall, mixed and backlog pacing; %0d checked",
               beats_checked);
      if (mismatches == 0) begin
         $display("set_operation_unit_top regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("set_operation_unit_top regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/sou_pkg.sv
hdl/sou_popcount.sv
hdl/sou_alu.sv
hdl/set_operation_unit_top.sv
test/tb.sv
